### src/xtea3_block_cipher_unit_defines.svh
// ----------------------------------------------------------------------------
// XTEA-3 assertion macros
// Assertion macros used by the checker file of the XTEA-3 cipher unit.
// ----------------------------------------------------------------------------
`ifndef XTEA3_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define XTEA3_BLOCK_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XTEA3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XTEA3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/xtea3_pkg.sv
// ----------------------------------------------------------------------------
// XTEA-3 package
// Shared types, constants and the keyed mix function of the XTEA-3 cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package xtea3_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [3:0][31:0] block_t;
  typedef logic [7:0][31:0] key_t;

  localparam word_t      Delta    = 32'h9E37_79B9;
  localparam int unsigned TopShift = 27;
  localparam int unsigned SumShift = 11;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_KEY_0_1  = 3'd0,
    CFG_KEY_2_3  = 3'd1,
    CFG_KEY_4_5  = 3'd2,
    CFG_KEY_6_7  = 3'd3,
    CFG_ROUNDS   = 3'd4
  } cfg_idx_e;

  // Left rotation by a 5-bit amount; an amount of zero gives the input back.
  function automatic word_t rotl(word_t v, logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

  // Keyed mix of word x with partner p, running sum s and key select sel.
  function automatic word_t mix(word_t x, word_t p, word_t s, logic [1:0] sel, key_t key);
    word_t left;
    word_t right;
    left  = (x << 4) + rotl(key[{1'b1, sel}], x[4:0]);
    right = (x >> 5) + rotl(key[{1'b0, sel}], x[TopShift +: 5]);
    return left ^ (p + s) ^ right;
  endfunction

endpackage

`default_nettype wire

### src/xtea3_round.sv
// ----------------------------------------------------------------------------
// XTEA-3 round unit
// One full encipher or decipher round, reused once per cycle by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea3_round (
  input  wire logic            decipher_i,
  input  xtea3_pkg::block_t    blk_i,
  input  xtea3_pkg::word_t     sum_i,
  input  xtea3_pkg::key_t      key_i,
  output xtea3_pkg::block_t    blk_o,
  output xtea3_pkg::word_t     sum_o
);

  xtea3_pkg::word_t sum_up;
  xtea3_pkg::word_t sum_dn;
  xtea3_pkg::word_t mix_a;
  xtea3_pkg::word_t mix_c;

  assign sum_up = sum_i + xtea3_pkg::Delta;
  assign sum_dn = sum_i - xtea3_pkg::Delta;

  // The two half-round mixes of one round are independent of each other.
  always_comb begin
    if (decipher_i) begin
      mix_c = xtea3_pkg::mix(blk_i[2], blk_i[0], sum_i,
                             sum_i[xtea3_pkg::SumShift +: 2], key_i);
      mix_a = xtea3_pkg::mix(blk_i[0], blk_i[2], sum_dn, sum_dn[1:0], key_i);
    end else begin
      mix_a = xtea3_pkg::mix(blk_i[1], blk_i[3], sum_i, sum_i[1:0], key_i);
      mix_c = xtea3_pkg::mix(blk_i[3], blk_i[1], sum_up,
                             sum_up[xtea3_pkg::SumShift +: 2], key_i);
    end
  end

  // Apply the mixes and rotate the word order.
  always_comb begin
    if (decipher_i) begin
      blk_o[0] = blk_i[3] - mix_a;
      blk_o[1] = blk_i[0];
      blk_o[2] = blk_i[1] - mix_c;
      blk_o[3] = blk_i[2];
      sum_o    = sum_dn;
    end else begin
      blk_o[0] = blk_i[1];
      blk_o[1] = blk_i[2] + mix_c;
      blk_o[2] = blk_i[3];
      blk_o[3] = blk_i[0] + mix_a;
      sum_o    = sum_up;
    end
  end

endmodule

`default_nettype wire

### src/xtea3_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// XTEA-3 block cipher unit
// Enciphers or deciphers one 128-bit block under a 256-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: key words and the round count are written through the
//   cfg_valid_i / cfg_ready_o channel (index 0..3 key word pairs, 4 rounds);
//   a transfer happens when both are high. Indexes above 4 are ignored.
//   Write it only while the unit is idle.
//   Command: a block is taken at a clock edge with start high and busy low;
//   cmd_i selects encipher (0) or decipher (1).
//   Result: out_word0_o..out_word3_o hold the result while done_o is high for
//   exactly one cycle; the receiver cannot hold it off.
//   Sequence: the start transfer loads the whitened block, the round unit then
//   applies the configured rounds, and a final step whitens the result into
//   the output registers and raises done_o. A new block can be started in the
//   cycle done_o is high. The shared round unit does one round per cycle and sets the rate.
//   Reset: keys clear to zero, the round count to 96, the unit goes idle.
// ----------------------------------------------------------------------------
`default_nettype none

module xtea3_block_cipher_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  // Command
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd_i,
  input  wire logic [31:0] in_word0_i,
  input  wire logic [31:0] in_word1_i,
  input  wire logic [31:0] in_word2_i,
  input  wire logic [31:0] in_word3_i,
  // Result
  output logic             done_o,
  output logic [31:0]      out_word0_o,
  output logic [31:0]      out_word1_o,
  output logic [31:0]      out_word2_o,
  output logic [31:0]      out_word3_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  xtea3_pkg::key_t   key_q;
  logic [7:0]        rounds_q;
  logic [7:0]        cnt_q, cnt_d;
  logic              dec_q;
  xtea3_pkg::block_t blk_q, blk_d;
  xtea3_pkg::word_t  sum_q, sum_d;
  xtea3_pkg::block_t res_q, res_d;
  logic              done_q, done_d;

  xtea3_pkg::block_t blk_in;
  xtea3_pkg::block_t blk_white;
  xtea3_pkg::block_t blk_rnd;
  xtea3_pkg::word_t  sum_rnd;
  xtea3_pkg::word_t  sum_init;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign busy        = (state_q == ST_RUN);

  assign blk_in = {in_word3_i, in_word2_i, in_word1_i, in_word0_i};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      rounds_q <= 8'd96;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        xtea3_pkg::CFG_KEY_0_1: key_q[1:0] <= cfg_data_i;
        xtea3_pkg::CFG_KEY_2_3: key_q[3:2] <= cfg_data_i;
        xtea3_pkg::CFG_KEY_4_5: key_q[5:4] <= cfg_data_i;
        xtea3_pkg::CFG_KEY_6_7: key_q[7:6] <= cfg_data_i;
        xtea3_pkg::CFG_ROUNDS:  rounds_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input whitening and the starting sum of a run: zero to encipher, Delta times the rounds to decipher.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (cmd_i) begin
        blk_white[i] = blk_in[i] ^ key_q[i + 4];
      end else begin
        blk_white[i] = blk_in[i] + key_q[i];
      end
    end
    sum_init = cmd_i ? xtea3_pkg::word_t'(xtea3_pkg::Delta * {24'd0, rounds_q}) : '0;
  end

  // Shared round unit.
  xtea3_round u_round (
    .decipher_i (dec_q),
    .blk_i      (blk_q),
    .sum_i      (sum_q),
    .key_i      (key_q),
    .blk_o      (blk_rnd),
    .sum_o      (sum_rnd)
  );

  // Sequencer: load, iterate the rounds, then whiten and present the result.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    blk_d   = blk_q;
    sum_d   = sum_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          blk_d   = blk_white;
          sum_d   = sum_init;
          cnt_d   = rounds_q;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == 8'd0) begin
          for (int i = 0; i < 4; i++) begin
            if (dec_q) begin
              res_d[i] = blk_q[i] - key_q[i];
            end else begin
              res_d[i] = blk_q[i] ^ key_q[i + 4];
            end
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          blk_d = blk_rnd;
          sum_d = sum_rnd;
          cnt_d = cnt_q - 8'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    sum_q <= sum_d;
    res_q <= res_d;
    if (accept) begin
      dec_q <= cmd_i;
    end
  end

  assign done_o      = done_q;
  assign out_word0_o = res_q[0];
  assign out_word1_o = res_q[1];
  assign out_word2_o = res_q[2];
  assign out_word3_o = res_q[3];

endmodule

`default_nettype wire

### src/xtea3_checker.sv
// ----------------------------------------------------------------------------
// XTEA-3 port checker
// Checks the command and result handshake seen at the unit's ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xtea3_block_cipher_unit_defines.svh"

module xtea3_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  // A start transfer always begins a run.
  `XTEA3_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy, "start transfer did not raise busy")

  // A result is shown only when the unit has finished its run.
  `XTEA3_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy, "result strobe while busy")

  // Each result is shown for exactly one cycle.
  `XTEA3_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe longer than one cycle")

  // Every run ends with a result.
  `XTEA3_ASSERT_NOW(a_run_result, clk_i, rst_ni, $fell(busy), done_o, "run ended without a result")

endmodule

bind xtea3_block_cipher_unit xtea3_checker u_xtea3_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

`default_nettype wire

### test/xtea3_block_cipher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA-3 block cipher unit testbench
// Drives blocks through the command port, predicts every result from an
// independent model of the cipher, and checks each done_o strobe against the
// oldest outstanding prediction. Keys and round counts change between phases.
// ----------------------------------------------------------------------------

module xtea3_block_cipher_unit_tb;

  // One block command as the driver holds it.
  typedef struct packed {
    logic              cmd;
    xtea3_pkg::block_t data;
  } cipher_req_t;

  // Pacing modes of the phases.
  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  localparam logic CMD_ENCIPHER = 1'b0;
  localparam logic CMD_DECIPHER = 1'b1;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [2:0]        cfg_index_i = '0;
  logic [63:0]       cfg_data_i = '0;
  logic              cfg_ready_o;
  logic              start = 1'b0;
  logic              busy;
  logic              cmd_drv = 1'b0;
  xtea3_pkg::block_t word_drv = '0;
  logic              done_o;
  logic [31:0]       out_word0_o;
  logic [31:0]       out_word1_o;
  logic [31:0]       out_word2_o;
  logic [31:0]       out_word3_o;

  // Testbench copy of the configuration registers.
  xtea3_pkg::word_t  model_key [8];
  logic [7:0]        model_rounds;

  cipher_req_t       pending_q [$];
  xtea3_pkg::block_t expected_blocks_q [$];
  int                blocks_in_flight = 0;
  int                mismatch_count = 0;
  int                sender_idle_pct = 0;

  xtea3_block_cipher_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_drv),
    .in_word0_i  (word_drv[0]),
    .in_word1_i  (word_drv[1]),
    .in_word2_i  (word_drv[2]),
    .in_word3_i  (word_drv[3]),
    .done_o      (done_o),
    .out_word0_o (out_word0_o),
    .out_word1_o (out_word1_o),
    .out_word2_o (out_word2_o),
    .out_word3_o (out_word3_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Cipher prediction
  // ---------------------------------------------------------------------------

  // Left rotation; an amount of zero leaves the word as it is.
  function automatic xtea3_pkg::word_t rotate_left(xtea3_pkg::word_t v, logic [4:0] amt);
    if (amt == 5'd0) return v;
    return (v << amt) | (v >> (6'd32 - amt));
  endfunction

  // Keyed mix of word x with its partner p, the running sum s and key select sel.
  function automatic xtea3_pkg::word_t keyed_mix(xtea3_pkg::word_t x, xtea3_pkg::word_t p,
                                                 xtea3_pkg::word_t s, logic [1:0] sel);
    xtea3_pkg::word_t left_part;
    xtea3_pkg::word_t right_part;
    left_part  = (x << 4) + rotate_left(model_key[4 + sel], x[4:0]);
    right_part = (x >> 5) + rotate_left(model_key[sel], x[31:27]);
    return left_part ^ (p + s) ^ right_part;
  endfunction

  function automatic xtea3_pkg::block_t encipher_block(xtea3_pkg::block_t blk);
    xtea3_pkg::word_t  a, b, c, d, s, t;
    xtea3_pkg::block_t res;
    a = blk[0] + model_key[0];
    b = blk[1] + model_key[1];
    c = blk[2] + model_key[2];
    d = blk[3] + model_key[3];
    s = '0;
    for (int i = 0; i < model_rounds; i++) begin
      a = a + keyed_mix(b, d, s, s[1:0]);
      s = s + xtea3_pkg::Delta;
      c = c + keyed_mix(d, b, s, s[12:11]);
      t = a; a = b; b = c; c = d; d = t;
    end
    res[0] = a ^ model_key[4];
    res[1] = b ^ model_key[5];
    res[2] = c ^ model_key[6];
    res[3] = d ^ model_key[7];
    return res;
  endfunction

  function automatic xtea3_pkg::block_t decipher_block(xtea3_pkg::block_t blk);
    xtea3_pkg::word_t  a, b, c, d, s, t;
    xtea3_pkg::block_t res;
    a = blk[0] ^ model_key[4];
    b = blk[1] ^ model_key[5];
    c = blk[2] ^ model_key[6];
    d = blk[3] ^ model_key[7];
    s = xtea3_pkg::Delta * {24'd0, model_rounds};
    for (int i = 0; i < model_rounds; i++) begin
      t = d; d = c; c = b; b = a; a = t;
      c = c - keyed_mix(d, b, s, s[12:11]);
      s = s - xtea3_pkg::Delta;
      a = a - keyed_mix(b, d, s, s[1:0]);
    end
    res[0] = a - model_key[0];
    res[1] = b - model_key[1];
    res[2] = c - model_key[2];
    res[3] = d - model_key[3];
    return res;
  endfunction

  function automatic xtea3_pkg::block_t predict_block(cipher_req_t req);
    if (req.cmd == CMD_DECIPHER) return decipher_block(req.data);
    return encipher_block(req.data);
  endfunction

  function automatic bit sender_holds_off();
    return $urandom_range(99, 0) < sender_idle_pct;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: a transfer happens at an edge with start high and busy low.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_blk
    cipher_req_t next_req;
    if (!rst_ni) begin
      start    <= 1'b0;
      cmd_drv  <= CMD_ENCIPHER;
      word_drv <= '0;
    end else begin
      // The registers still hold the block that was taken at this edge.
      if (start && !busy) begin
        expected_blocks_q.push_back(predict_block({cmd_drv, word_drv}));
      end
      if (!start || !busy) begin
        if (pending_q.size() != 0 && !sender_holds_off()) begin
          next_req = pending_q.pop_front();
          start    <= 1'b1;
          cmd_drv  <= next_req.cmd;
          word_drv <= next_req.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each done_o strobe is one transfer that cannot be held off.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_blk
    xtea3_pkg::block_t want;
    xtea3_pkg::block_t got;
    if (rst_ni && done_o) begin
      got = {out_word3_o, out_word2_o, out_word1_o, out_word0_o};
      if (expected_blocks_q.size() == 0) begin
        $error("result %h with no block outstanding", got);
        mismatch_count++;
      end else begin
        want = expected_blocks_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i]) begin
            $error("out_word%0d: expected %h, actual %h", i, want[i], got[i]);
            mismatch_count++;
          end
        end
        blocks_in_flight--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // Indexes past the round count are ignored by the unit.
    if (idx < xtea3_pkg::CFG_ROUNDS) begin
      model_key[2 * idx]     = data[31:0];
      model_key[2 * idx + 1] = data[63:32];
    end else if (idx == xtea3_pkg::CFG_ROUNDS) begin
      model_rounds = data[7:0];
    end
  endtask

  // Writes all key pairs and the round count; upper data bits of the
  // round count write carry noise that the unit must drop.
  task automatic load_settings(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
                               logic [63:0] k67, logic [7:0] rounds);
    write_reg(xtea3_pkg::CFG_KEY_0_1, k01);
    write_reg(xtea3_pkg::CFG_KEY_2_3, k23);
    write_reg(xtea3_pkg::CFG_KEY_4_5, k45);
    write_reg(xtea3_pkg::CFG_KEY_6_7, k67);
    write_reg(xtea3_pkg::CFG_ROUNDS,
              {$urandom, 24'($urandom_range(16777215, 0)), rounds});
  endtask

  task automatic push_block(logic cmd, xtea3_pkg::word_t w0, xtea3_pkg::word_t w1,
                            xtea3_pkg::word_t w2, xtea3_pkg::word_t w3);
    pending_q.push_back({cmd, w3, w2, w1, w0});
    blocks_in_flight++;
  endtask

  // Waits until every block has come back and the unit is idle.
  task automatic wait_drained();
    do @(posedge clk_i); while (blocks_in_flight != 0 || busy || start);
  endtask

  function automatic xtea3_pkg::word_t random_word();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] random_key_pair();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pace_to_pct(pace_e pace);
    // The receiver takes every strobe, so receiver stalls have no effect.
    case (pace)
      PACE_SENDER_IDLE: return 71;
      PACE_BOTH:        return 13;
      default:          return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_blk
    pace_e      pace;
    logic [7:0] rounds;
    int         n_blocks;

    for (int i = 0; i < 8; i++) model_key[i] = '0;
    model_rounds = 8'd96;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero key, 96 rounds.
    push_block(CMD_ENCIPHER, '0, '0, '0, '0);
    push_block(CMD_DECIPHER, '0, '0, '0, '0);
    push_block(CMD_ENCIPHER, '1, '1, '1, '1);
    push_block(CMD_DECIPHER, '1, '1, '1, '1);
    wait_drained();

    // Zero rounds leave only the key additions or subtractions and XORs.
    load_settings('1, '1, '1, '1, 8'd0);
    push_block(CMD_ENCIPHER, 32'hFFFF_FFE0, 32'h07FF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    push_block(CMD_DECIPHER, 32'hFFFF_FFE0, 32'h07FF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    push_block(CMD_ENCIPHER, $urandom, $urandom, $urandom, $urandom);
    wait_drained();

    // Writes past the last register must not disturb the settings.
    load_settings(random_key_pair(), random_key_pair(), random_key_pair(),
                  random_key_pair(), 8'd1);
    for (int i = 5; i <= 7; i++) begin
      write_reg(3'(xtea3_pkg::CFG_ROUNDS) + 3'(i - 4), {$urandom, $urandom});
    end
    push_block(CMD_ENCIPHER, $urandom, $urandom, $urandom, $urandom);
    push_block(CMD_DECIPHER, $urandom, $urandom, $urandom, $urandom);
    push_block(CMD_ENCIPHER, 32'h0000_001F, 32'hF800_0000, 32'h8000_0000, 32'h0000_0001);
    wait_drained();

    // Largest 8-bit round count.
    write_reg(xtea3_pkg::CFG_ROUNDS, {56'd0, 8'd255});
    push_block(CMD_ENCIPHER, $urandom, $urandom, $urandom, $urandom);
    push_block(CMD_DECIPHER, '1, '0, '1, '0);
    wait_drained();

    // Ends of the intended range.
    load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 8'd64);
    push_block(CMD_ENCIPHER, $urandom, $urandom, $urandom, $urandom);
    push_block(CMD_DECIPHER, $urandom, $urandom, $urandom, $urandom);
    wait_drained();
    write_reg(xtea3_pkg::CFG_ROUNDS, {56'd0, 8'd128});
    push_block(CMD_ENCIPHER, $urandom, $urandom, $urandom, $urandom);
    push_block(CMD_DECIPHER, $urandom, $urandom, $urandom, $urandom);
    wait_drained();

    // Random phases with fresh settings and pacing each time.
    for (int phase = 0; phase < 10; phase++) begin
      pace = pace_e'(phase % 4);
      sender_idle_pct = pace_to_pct(pace);
      n_blocks = 120;
      case (phase)
        3:       rounds = 8'd128;
        6:       rounds = 8'd64;
        8: begin
          rounds   = 8'($urandom_range(255, 0));
          n_blocks = 40;
        end
        default: rounds = 8'($urandom_range(128, 64));
      endcase
      load_settings(random_key_pair(), random_key_pair(), random_key_pair(),
                    random_key_pair(), rounds);
      if ($urandom_range(2, 0) == 0) begin
        write_reg(3'(xtea3_pkg::CFG_ROUNDS) + 3'($urandom_range(3, 1)),
                  {$urandom, $urandom});
      end
      for (int n = 0; n < n_blocks; n++) begin
        push_block(1'($urandom_range(1, 0)), random_word(), random_word(),
                   random_word(), random_word());
      end
      wait_drained();
    end

    // Let any stray strobe show up before the verdict.
    repeat (300) @(posedge clk_i);
    if (expected_blocks_q.size() != 0) begin
      $error("%0d predicted blocks never came back", expected_blocks_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/xtea3_pkg.sv
src/xtea3_round.sv
src/xtea3_block_cipher_unit.sv
src/xtea3_checker.sv
test/xtea3_block_cipher_unit_tb.sv
